FILE: rtl/vcsp_pkg.sv
// Shared types, codes and limits for the voice container stream parser.
// No dependencies; used by every module under rtl/.
package vcsp_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_HEADER = 3'd1,
        PH_TEXT   = 3'd2,
        PH_CODES  = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_CODE   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_VERSION   = 3'd2;
    localparam logic [2:0] ERR_BOUNDS    = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;
    localparam logic [2:0] ERR_TRAILING  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_CODEBOOKS   = 2'd0;
    localparam logic [1:0] CFG_MAX_FRAMES      = 2'd1;
    localparam logic [1:0] CFG_MAX_TEXT_LENGTH = 2'd2;

    // Header word positions
    localparam logic [2:0] HDR_VERSION = 3'd0;
    localparam logic [2:0] HDR_RATE    = 3'd1;
    localparam logic [2:0] HDR_BOOKS   = 3'd2;
    localparam logic [2:0] HDR_FRAMES  = 3'd3;

    // Format limits, also the reset values of the limit registers
    localparam logic [31:0] FORMAT_VERSION = 32'd1;
    localparam logic [6:0]  BOOKS_CAP      = 7'd64;
    localparam logic [16:0] FRAMES_CAP     = 17'd100000;
    localparam logic [20:0] TEXT_CAP       = 21'd1048576;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] item_value;
        logic [2:0]         fault_code;
        logic [31:0]        header_rate;
        logic [6:0]         codebook_count;
        logic [16:0]        frame_count;
    } out_item_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h42;
            2'd1:    b = 8'h52;
            2'd2:    b = 8'h5A;
            default: b = 8'h56;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/vcsp_parser.sv
// Byte parser: magic check, header assembly, bounds checks, text and code
// extraction, verdict. Holds the limit registers. Depends on vcsp_pkg.
module vcsp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  vcsp_pkg::in_item_t item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [20:0]        cfg_data,
    output logic [1:0]         push_cnt,
    output vcsp_pkg::out_item_t push_a,
    output vcsp_pkg::out_item_t push_b
);

    vcsp_pkg::phase_t phase_reg, phase_next, phase_step;
    logic [1:0]  biw_reg, biw_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [31:0] rate_reg, rate_next;
    logic [6:0]  books_reg, books_next;
    logic [16:0] frames_reg, frames_next;
    logic [20:0] text_reg, text_next;
    logic [22:0] codes_reg, codes_next;
    logic [2:0]  error_reg, error_next, error_step;

    logic [6:0]  max_books_reg;
    logic [16:0] max_frames_reg;
    logic [20:0] max_text_reg;

    logic [6:0]  lim_books;
    logic [16:0] lim_frames;
    logic [20:0] lim_text;
    logic [31:0] shifted;
    logic [22:0] code_total;

    vcsp_pkg::out_item_t data_res, verdict_res;
    logic data_emit, verdict_emit;

    assign lim_books  = (max_books_reg < vcsp_pkg::BOOKS_CAP) ? max_books_reg
                                                              : vcsp_pkg::BOOKS_CAP;
    assign lim_frames = (max_frames_reg < vcsp_pkg::FRAMES_CAP) ? max_frames_reg
                                                                : vcsp_pkg::FRAMES_CAP;
    assign lim_text   = (max_text_reg < vcsp_pkg::TEXT_CAP) ? max_text_reg
                                                            : vcsp_pkg::TEXT_CAP;
    assign shifted    = {item.data_byte, word_reg[31:8]};
    assign code_total = {6'd0, frames_reg} * {16'd0, books_reg};

    // Next state
    always_comb
    begin
        phase_step  = phase_reg;
        error_step  = error_reg;
        biw_next    = biw_reg;
        word_next   = word_reg;
        hidx_next   = hidx_reg;
        rate_next   = rate_reg;
        books_next  = books_reg;
        frames_next = frames_reg;
        text_next   = text_reg;
        codes_next  = codes_reg;
        if (accept)
        begin
            unique case (phase_reg)
                vcsp_pkg::PH_MAGIC:
                begin
                    if (item.data_byte != vcsp_pkg::magic_byte(biw_reg))
                    begin
                        phase_step = vcsp_pkg::PH_ERROR;
                        error_step = vcsp_pkg::ERR_MAGIC;
                    end
                    else if (biw_reg == 2'd3)
                    begin
                        biw_next   = 2'd0;
                        phase_step = vcsp_pkg::PH_HEADER;
                    end
                    else
                    begin
                        biw_next = biw_reg + 2'd1;
                    end
                end
                vcsp_pkg::PH_HEADER:
                begin
                    word_next = shifted;
                    if (biw_reg != 2'd3)
                    begin
                        biw_next = biw_reg + 2'd1;
                    end
                    else
                    begin
                        biw_next  = 2'd0;
                        word_next = '0;
                        hidx_next = hidx_reg + 3'd1;
                        unique case (hidx_reg)
                            vcsp_pkg::HDR_VERSION:
                            begin
                                if (shifted != vcsp_pkg::FORMAT_VERSION)
                                begin
                                    phase_step = vcsp_pkg::PH_ERROR;
                                    error_step = vcsp_pkg::ERR_VERSION;
                                end
                            end
                            vcsp_pkg::HDR_RATE:
                            begin
                                rate_next = shifted;
                            end
                            vcsp_pkg::HDR_BOOKS:
                            begin
                                if (shifted == 32'd0 || shifted > {25'd0, lim_books})
                                begin
                                    phase_step = vcsp_pkg::PH_ERROR;
                                    error_step = vcsp_pkg::ERR_BOUNDS;
                                end
                                else
                                begin
                                    books_next = shifted[6:0];
                                end
                            end
                            vcsp_pkg::HDR_FRAMES:
                            begin
                                if (shifted == 32'd0 || shifted > {15'd0, lim_frames})
                                begin
                                    phase_step = vcsp_pkg::PH_ERROR;
                                    error_step = vcsp_pkg::ERR_BOUNDS;
                                end
                                else
                                begin
                                    frames_next = shifted[16:0];
                                end
                            end
                            default:
                            begin
                                if (shifted > {11'd0, lim_text})
                                begin
                                    phase_step = vcsp_pkg::PH_ERROR;
                                    error_step = vcsp_pkg::ERR_BOUNDS;
                                end
                                else
                                begin
                                    text_next  = shifted[20:0];
                                    codes_next = code_total;
                                    phase_step = (shifted != 32'd0) ? vcsp_pkg::PH_TEXT
                                                                    : vcsp_pkg::PH_CODES;
                                end
                            end
                        endcase
                    end
                end
                vcsp_pkg::PH_TEXT:
                begin
                    text_next = text_reg - 21'd1;
                    if (text_reg == 21'd1)
                    begin
                        phase_step = vcsp_pkg::PH_CODES;
                    end
                end
                vcsp_pkg::PH_CODES:
                begin
                    word_next = shifted;
                    if (biw_reg != 2'd3)
                    begin
                        biw_next = biw_reg + 2'd1;
                    end
                    else
                    begin
                        biw_next   = 2'd0;
                        word_next  = '0;
                        codes_next = codes_reg - 23'd1;
                        if (codes_reg == 23'd1)
                        begin
                            phase_step = vcsp_pkg::PH_DONE;
                        end
                    end
                end
                vcsp_pkg::PH_DONE:
                begin
                    phase_step = vcsp_pkg::PH_ERROR;
                    error_step = vcsp_pkg::ERR_TRAILING;
                end
                default:
                begin
                end
            endcase
        end

        phase_next = phase_step;
        error_next = error_step;
        // Last byte: verdict goes out, then start over on a fresh buffer
        if (accept && item.is_last)
        begin
            phase_next  = vcsp_pkg::PH_MAGIC;
            error_next  = vcsp_pkg::ERR_NONE;
            biw_next    = 2'd0;
            word_next   = '0;
            hidx_next   = 3'd0;
            rate_next   = '0;
            books_next  = '0;
            frames_next = '0;
            text_next   = '0;
            codes_next  = '0;
        end
    end

    // Outputs
    always_comb
    begin
        data_emit    = 1'b0;
        data_res     = '0;
        verdict_emit = accept && item.is_last;
        verdict_res  = '0;
        verdict_res.kind = vcsp_pkg::KIND_REJECT;
        if (accept)
        begin
            if (phase_reg == vcsp_pkg::PH_TEXT)
            begin
                data_emit           = 1'b1;
                data_res.kind       = vcsp_pkg::KIND_TEXT;
                data_res.item_value = {24'd0, item.data_byte};
            end
            else if (phase_reg == vcsp_pkg::PH_CODES && biw_reg == 2'd3)
            begin
                data_emit           = 1'b1;
                data_res.kind       = vcsp_pkg::KIND_CODE;
                data_res.item_value = shifted;
            end
        end
        unique case (phase_step) inside
            vcsp_pkg::PH_DONE:
            begin
                verdict_res.kind           = vcsp_pkg::KIND_ACCEPT;
                verdict_res.header_rate    = rate_next;
                verdict_res.codebook_count = books_next;
                verdict_res.frame_count    = frames_next;
            end
            vcsp_pkg::PH_MAGIC, vcsp_pkg::PH_HEADER, vcsp_pkg::PH_TEXT, vcsp_pkg::PH_CODES:
            begin
                verdict_res.fault_code = vcsp_pkg::ERR_TRUNCATED;
            end
            default:
            begin
                verdict_res.fault_code = error_step;
            end
        endcase
        // Header fields of the verdict come from the held values before the clear
        if (phase_step == vcsp_pkg::PH_DONE)
        begin
            verdict_res.header_rate    = rate_reg;
            verdict_res.codebook_count = books_reg;
            verdict_res.frame_count    = frames_reg;
        end

        push_cnt = {1'b0, data_emit} + {1'b0, verdict_emit};
        push_a   = data_emit ? data_res : verdict_res;
        push_b   = verdict_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= vcsp_pkg::PH_MAGIC;
            biw_reg    <= '0;
            word_reg   <= '0;
            hidx_reg   <= '0;
            rate_reg   <= '0;
            books_reg  <= '0;
            frames_reg <= '0;
            text_reg   <= '0;
            codes_reg  <= '0;
            error_reg  <= vcsp_pkg::ERR_NONE;
        end
        else
        begin
            phase_reg  <= phase_next;
            biw_reg    <= biw_next;
            word_reg   <= word_next;
            hidx_reg   <= hidx_next;
            rate_reg   <= rate_next;
            books_reg  <= books_next;
            frames_reg <= frames_next;
            text_reg   <= text_next;
            codes_reg  <= codes_next;
            error_reg  <= error_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_books_reg  <= vcsp_pkg::BOOKS_CAP;
            max_frames_reg <= vcsp_pkg::FRAMES_CAP;
            max_text_reg   <= vcsp_pkg::TEXT_CAP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vcsp_pkg::CFG_MAX_CODEBOOKS:   max_books_reg  <= cfg_data[6:0];
                vcsp_pkg::CFG_MAX_FRAMES:      max_frames_reg <= cfg_data[16:0];
                vcsp_pkg::CFG_MAX_TEXT_LENGTH: max_text_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.is_last |=> phase_reg == vcsp_pkg::PH_MAGIC && hidx_reg == 3'd0)
        else $error("parser did not restart after last byte");

    a_second_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> push_b.kind == vcsp_pkg::KIND_ACCEPT
                          || push_b.kind == vcsp_pkg::KIND_REJECT)
        else $error("second result of a beat is not a verdict");

    a_codes_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == vcsp_pkg::PH_CODES |-> codes_reg != 23'd0)
        else $error("code phase with no code words left");

endmodule

FILE: rtl/vcsp_out_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on vcsp_pkg.
module vcsp_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  vcsp_pkg::out_item_t push_a,
    input  vcsp_pkg::out_item_t push_b,
    input  logic                pop,
    output vcsp_pkg::out_item_t head,
    output logic                not_empty,
    output logic                room_for_two
);

    vcsp_pkg::out_item_t mem_reg [vcsp_pkg::FIFO_DEPTH];
    logic [vcsp_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [vcsp_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vcsp_pkg::FIFO_CW-1:0] count_reg, count_next;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + push_cnt[vcsp_pkg::FIFO_AW-1:0];
    assign rd_ptr_next  = rd_ptr_reg + {{(vcsp_pkg::FIFO_AW-1){1'b0}}, pop};
    assign count_next   = count_reg
                        + {{(vcsp_pkg::FIFO_CW-2){1'b0}}, push_cnt}
                        - {{(vcsp_pkg::FIFO_CW-1){1'b0}}, pop};

    assign head         = mem_reg[rd_ptr_reg];
    assign not_empty    = count_reg != '0;
    assign room_for_two = count_reg <= vcsp_pkg::FIFO_CW'(vcsp_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vcsp_pkg::FIFO_CW'(vcsp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |=> count_reg != '0)
        else $error("pushed result not held");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push_cnt == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not drain one entry");

endmodule

FILE: rtl/voice_container_stream_parser.sv
// Top level of the voice container stream parser.
// Depends on vcsp_pkg, vcsp_parser and vcsp_out_fifo.
//
// Usage:
//   item channel (item_valid/item_ready/item): one container byte per beat,
//   with is_last set on the final byte of a buffer.
//   result channel (result_valid/result_ready/result): text bytes, code words
//   and one verdict per buffer (accepted with header fields, or rejected
//   with an error code). Results of a rejected buffer are to be discarded.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): limit registers,
//   always ready; write only while the parser is idle.
// Timing:
//   A byte is parsed in the cycle it is accepted; its results are written
//   into a four-entry result queue, whose head drives the result port.
//   One byte per cycle while the queue has room. A last byte that also
//   finishes a text byte or code word yields two results.
//   item_ready drops while the queue holds more than two results, so a
//   stalled receiver backs up into the byte stream without losing results.
// Reset: parser expects a new buffer, queue empty, limits at format maxima.
module voice_container_stream_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  vcsp_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output vcsp_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [20:0]         cfg_data
);

    logic                accept;
    logic                room_for_two;
    logic [1:0]          push_cnt;
    vcsp_pkg::out_item_t push_a;
    vcsp_pkg::out_item_t push_b;

    assign item_ready = room_for_two;
    assign accept     = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    vcsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push_cnt  (push_cnt),
        .push_a    (push_a),
        .push_b    (push_b)
    );

    vcsp_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (push_cnt),
        .push_a       (push_a),
        .push_b       (push_b),
        .pop          (result_valid && result_ready),
        .head         (result),
        .not_empty    (result_valid),
        .room_for_two (room_for_two)
    );

endmodule

FILE: bench/tb.sv
// Self-checking bench for voice_container_stream_parser: drives container buffers byte by
// byte, predicts every text, code and verdict beat, and checks them field by field.
// Depends on vcsp_pkg and the RTL under rtl/.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_BYTES    = 250;
    localparam int DIRECTED_ROWS  = 20;
    localparam int MAX_PRINTS     = 30;
    // magic bytes in arrival order, lowest byte first
    localparam logic [31:0] MAGIC_LE = 32'h565A5242;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
        logic [2:0] want_error;
    } script_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    vcsp_pkg::in_item_t  item;
    logic                result_valid;
    logic                result_ready = 1'b0;
    vcsp_pkg::out_item_t result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [20:0]         cfg_data;

    voice_container_stream_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Parser state as predicted from accepted beats
    vcsp_pkg::phase_t ph_q;
    logic [1:0]  biw_q;
    logic [31:0] shift_q;
    logic [2:0]  hidx_q;
    logic [31:0] rate_q;
    logic [6:0]  books_q;
    logic [16:0] frames_q;
    logic [20:0] text_q;
    logic [22:0] codes_q;
    logic [2:0]  err_q;
    logic [6:0]  lim_books;
    logic [16:0] lim_frames;
    logic [20:0] lim_text;

    vcsp_pkg::out_item_t expected_results [$];
    logic [2:0]  verdict_hints [$];
    logic [7:0]  pkt_bytes [$];
    script_row_t script [DIRECTED_ROWS];

    bit          steady = 1'b0;
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          buffers_sent = 0;
    int          text_seen = 0;
    int          codes_seen = 0;
    int          accepts_seen = 0;
    int          rejects_seen = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    logic [2:0]  hint_now;

    function automatic vcsp_pkg::out_item_t mk_result(input logic [1:0] kind,
                                                      input logic [31:0] value,
                                                      input logic [2:0] err,
                                                      input logic [31:0] rate,
                                                      input logic [6:0] books,
                                                      input logic [16:0] frames);
        vcsp_pkg::out_item_t r;
        r.kind           = kind;
        r.item_value     = value;
        r.fault_code     = err;
        r.header_rate    = rate;
        r.codebook_count = books;
        r.frame_count    = frames;
        return r;
    endfunction

    task automatic add_expected(input vcsp_pkg::out_item_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic add_byte(input logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endtask

    function automatic int books_limit();
        return (lim_books < vcsp_pkg::BOOKS_CAP) ? int'(lim_books) : int'(vcsp_pkg::BOOKS_CAP);
    endfunction

    function automatic int frames_limit();
        return (lim_frames < vcsp_pkg::FRAMES_CAP) ? int'(lim_frames)
                                                   : int'(vcsp_pkg::FRAMES_CAP);
    endfunction

    function automatic int text_limit();
        return (lim_text < vcsp_pkg::TEXT_CAP) ? int'(lim_text) : int'(vcsp_pkg::TEXT_CAP);
    endfunction

    task automatic clear_parse();
        ph_q     = vcsp_pkg::PH_MAGIC;
        biw_q    = '0;
        shift_q  = '0;
        hidx_q   = '0;
        rate_q   = '0;
        books_q  = '0;
        frames_q = '0;
        text_q   = '0;
        codes_q  = '0;
        err_q    = vcsp_pkg::ERR_NONE;
    endtask

    task automatic fail_parse(input logic [2:0] code);
        ph_q  = vcsp_pkg::PH_ERROR;
        err_q = code;
    endtask

    task automatic take_header_word(input logic [31:0] w);
        case (hidx_q)
            vcsp_pkg::HDR_VERSION:
                if (w != vcsp_pkg::FORMAT_VERSION)
                    fail_parse(vcsp_pkg::ERR_VERSION);
            vcsp_pkg::HDR_RATE:
                rate_q = w;
            vcsp_pkg::HDR_BOOKS:
                if (w == 0 || w > 32'(books_limit()))
                    fail_parse(vcsp_pkg::ERR_BOUNDS);
                else
                    books_q = w[6:0];
            vcsp_pkg::HDR_FRAMES:
                if (w == 0 || w > 32'(frames_limit()))
                    fail_parse(vcsp_pkg::ERR_BOUNDS);
                else
                    frames_q = w[16:0];
            default:
                if (w > 32'(text_limit()))
                begin
                    fail_parse(vcsp_pkg::ERR_BOUNDS);
                end
                else
                begin
                    text_q  = w[20:0];
                    codes_q = 23'(frames_q) * 23'(books_q);
                    ph_q    = (text_q != 0) ? vcsp_pkg::PH_TEXT : vcsp_pkg::PH_CODES;
                end
        endcase
        hidx_q = hidx_q + 3'd1;
    endtask

    // Advance the predicted parser by one accepted beat and queue what it yields
    task automatic parse_step(input vcsp_pkg::in_item_t beat);
        logic [7:0] b;
        b = beat.data_byte;
        case (ph_q)
            vcsp_pkg::PH_MAGIC:
                if (b != MAGIC_LE[8*biw_q +: 8])
                    fail_parse(vcsp_pkg::ERR_MAGIC);
                else if (biw_q == 2'd3)
                begin
                    biw_q = '0;
                    ph_q  = vcsp_pkg::PH_HEADER;
                end
                else
                    biw_q = biw_q + 2'd1;
            vcsp_pkg::PH_HEADER:
            begin
                shift_q = {b, shift_q[31:8]};
                if (biw_q != 2'd3)
                    biw_q = biw_q + 2'd1;
                else
                begin
                    biw_q = '0;
                    take_header_word(shift_q);
                    shift_q = '0;
                end
            end
            vcsp_pkg::PH_TEXT:
            begin
                add_expected(mk_result(vcsp_pkg::KIND_TEXT, {24'd0, b}, vcsp_pkg::ERR_NONE,
                                       '0, '0, '0));
                text_q = text_q - 21'd1;
                if (text_q == 0)
                    ph_q = vcsp_pkg::PH_CODES;
            end
            vcsp_pkg::PH_CODES:
            begin
                shift_q = {b, shift_q[31:8]};
                if (biw_q != 2'd3)
                    biw_q = biw_q + 2'd1;
                else
                begin
                    biw_q = '0;
                    add_expected(mk_result(vcsp_pkg::KIND_CODE, shift_q, vcsp_pkg::ERR_NONE,
                                           '0, '0, '0));
                    shift_q = '0;
                    codes_q = codes_q - 23'd1;
                    if (codes_q == 0)
                        ph_q = vcsp_pkg::PH_DONE;
                end
            end
            vcsp_pkg::PH_DONE:
                fail_parse(vcsp_pkg::ERR_TRAILING);
            default:
                ;
        endcase
        if (beat.is_last)
        begin
            case (ph_q)
                vcsp_pkg::PH_DONE:
                    add_expected(mk_result(vcsp_pkg::KIND_ACCEPT, '0, vcsp_pkg::ERR_NONE,
                                           rate_q, books_q, frames_q));
                vcsp_pkg::PH_MAGIC, vcsp_pkg::PH_HEADER, vcsp_pkg::PH_TEXT,
                vcsp_pkg::PH_CODES:
                    add_expected(mk_result(vcsp_pkg::KIND_REJECT, '0, vcsp_pkg::ERR_TRUNCATED,
                                           '0, '0, '0));
                default:
                    add_expected(mk_result(vcsp_pkg::KIND_REJECT, '0, err_q, '0, '0, '0));
            endcase
            clear_parse();
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task automatic check_result(input vcsp_pkg::out_item_t got);
        vcsp_pkg::out_item_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result beat kind %0d with nothing pending", got.kind));
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.item_value !== want.item_value)
            report_mismatch($sformatf("item_value %0h, want %0h", got.item_value, want.item_value));
        if (got.fault_code !== want.fault_code)
            report_mismatch($sformatf("fault_code %0d, want %0d", got.fault_code, want.fault_code));
        if (got.header_rate !== want.header_rate)
            report_mismatch($sformatf("header_rate %0h, want %0h",
                                      got.header_rate, want.header_rate));
        if (got.codebook_count !== want.codebook_count)
            report_mismatch($sformatf("codebook_count %0d, want %0d",
                                      got.codebook_count, want.codebook_count));
        if (got.frame_count !== want.frame_count)
            report_mismatch($sformatf("frame_count %0d, want %0d",
                                      got.frame_count, want.frame_count));
        case (want.kind)
            vcsp_pkg::KIND_TEXT:   text_seen++;
            vcsp_pkg::KIND_CODE:   codes_seen++;
            vcsp_pkg::KIND_ACCEPT: accepts_seen++;
            default:               rejects_seen++;
        endcase
    endtask

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            add_byte(w[8*i +: 8]);
    endtask

    // Assemble one container: mostly well formed, the rest broken in one way each
    task automatic build_buffer();
        int flavor;
        int lb;
        int lf;
        int lt;
        int books;
        int frames;
        int txt_count;
        int n;
        logic [31:0] version;
        lb = books_limit();
        lf = frames_limit();
        lt = text_limit();
        pkt_bytes = {};
        flavor = $urandom_range(0, 99);
        if (flavor < 8)
        begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
                add_byte(8'($urandom_range(0, 255)));
            return;
        end
        books     = (lb == 0) ? 1 : $urandom_range(1, (lb < 4) ? lb : 4);
        frames    = (lf == 0) ? 1 : $urandom_range(1, (lf < 3) ? lf : 3);
        txt_count = $urandom_range(0, (lt < 6) ? lt : 6);
        version   = vcsp_pkg::FORMAT_VERSION;
        if (flavor >= 14 && flavor < 20)
        begin
            version = ($urandom_range(0, 1) != 0) ? 32'd2 : $urandom;
            if (version == vcsp_pkg::FORMAT_VERSION)
                version = 32'd0;
        end
        else if (flavor >= 20 && flavor < 28)
        begin
            case ($urandom_range(0, 6))
                0:       books = 0;
                1:       books = lb + 1;
                2:       frames = 0;
                3:       frames = lf + 1;
                4:       txt_count = lt + 1;
                5:       books = int'($urandom | 32'h100);
                default: txt_count = int'($urandom | 32'h0020_0000);
            endcase
        end
        else if (flavor >= 28 && flavor < 33)
        begin
            // counts right at the limits; the body below holds at most 8 text bytes and 12 code words
            books     = (lb == 0) ? 1 : lb;
            frames    = (lf == 0) ? 1 : lf;
            txt_count = lt;
        end
        add_word(MAGIC_LE);
        add_word(version);
        add_word($urandom);
        add_word(32'(books));
        add_word(32'(frames));
        add_word(32'(txt_count));
        n = (txt_count >= 0 && txt_count < 8) ? txt_count : 8;
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
        n = (books > 0 && frames > 0 && books * frames < 12) ? books * frames : 12;
        for (int i = 0; i < n; i++)
            add_word(pick_word());
        if (flavor >= 8 && flavor < 14)
        begin
            n = $urandom_range(0, 3);
            pkt_bytes[n] = pkt_bytes[n] ^ 8'($urandom_range(1, 255));
        end
        else if (flavor >= 33 && flavor < 41)
        begin
            n = $urandom_range(1, pkt_bytes.size() - 1);
            while (pkt_bytes.size() > n)
                void'(pkt_bytes.pop_back());
        end
        else if (flavor >= 41 && flavor < 48)
        begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Present one byte and hold it until the beat is taken
    task automatic send_byte(input logic [7:0] b, input logic is_end, input logic [2:0] hint);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid     <= 1'b1;
        item.data_byte <= b;
        item.is_last   <= is_end;
        verdict_hints.insert(verdict_hints.size(), hint);
        do
            @(posedge clk);
        while (!item_ready);
        bytes_sent++;
    endtask

    task automatic program_limits(input logic [6:0] books, input logic [16:0] frames,
                                  input logic [20:0] txt_limit);
        logic [1:0]  idx [3];
        logic [20:0] val [3];
        idx = '{vcsp_pkg::CFG_MAX_CODEBOOKS, vcsp_pkg::CFG_MAX_FRAMES,
                vcsp_pkg::CFG_MAX_TEXT_LENGTH};
        val = '{21'(books), 21'(frames), txt_limit};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                vcsp_pkg::CFG_MAX_CODEBOOKS: lim_books  = val[i][6:0];
                vcsp_pkg::CFG_MAX_FRAMES:    lim_frames = val[i][16:0];
                default:                     lim_text   = val[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Predict on every accepted byte, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                hint_now = verdict_hints.pop_front();
                parse_step(item);
                if (hint_now != vcsp_pkg::ERR_NONE)
                    expected_results[expected_results.size() - 1] =
                        mk_result(vcsp_pkg::KIND_REJECT, '0, hint_now, '0, '0, '0);
            end
            if (result_valid && result_ready)
                check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [6:0]  set_books [5];
        logic [16:0] set_frames [5];
        logic [20:0] set_text [5];
        int start;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = vcsp_pkg::CFG_MAX_CODEBOOKS;
        cfg_data   = '0;
        lim_books  = vcsp_pkg::BOOKS_CAP;
        lim_frames = vcsp_pkg::FRAMES_CAP;
        lim_text   = vcsp_pkg::TEXT_CAP;
        clear_parse();
        set_books  = '{7'd1, 7'd127, 7'd0, 7'd3, vcsp_pkg::BOOKS_CAP};
        set_frames = '{17'd1, 17'd131071, 17'd0, 17'd2, vcsp_pkg::FRAMES_CAP};
        set_text   = '{21'd0, 21'd2097151, 21'd0, 21'd5, vcsp_pkg::TEXT_CAP};
        // bad magic alone, bad magic at the fourth byte, cut after magic,
        // wrong version, and a later byte that must not mask the first error
        script = '{
            '{8'h00, 1'b1, vcsp_pkg::ERR_MAGIC},
            '{8'h42, 1'b0, vcsp_pkg::ERR_NONE}, '{8'h52, 1'b0, vcsp_pkg::ERR_NONE},
            '{8'h5A, 1'b0, vcsp_pkg::ERR_NONE}, '{8'hFF, 1'b1, vcsp_pkg::ERR_MAGIC},
            '{8'h42, 1'b0, vcsp_pkg::ERR_NONE}, '{8'h52, 1'b0, vcsp_pkg::ERR_NONE},
            '{8'h5A, 1'b0, vcsp_pkg::ERR_NONE}, '{8'h56, 1'b1, vcsp_pkg::ERR_TRUNCATED},
            '{8'h42, 1'b0, vcsp_pkg::ERR_NONE}, '{8'h52, 1'b0, vcsp_pkg::ERR_NONE},
            '{8'h5A, 1'b0, vcsp_pkg::ERR_NONE}, '{8'h56, 1'b0, vcsp_pkg::ERR_NONE},
            '{8'h02, 1'b0, vcsp_pkg::ERR_NONE}, '{8'h00, 1'b0, vcsp_pkg::ERR_NONE},
            '{8'h00, 1'b0, vcsp_pkg::ERR_NONE}, '{8'h00, 1'b1, vcsp_pkg::ERR_VERSION},
            '{8'h42, 1'b0, vcsp_pkg::ERR_NONE}, '{8'h00, 1'b0, vcsp_pkg::ERR_NONE},
            '{8'h56, 1'b1, vcsp_pkg::ERR_MAGIC}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_byte(script[i].data_byte, script[i].is_end, script[i].want_error);

        // first pass at reset limits, then one pass per limit setting
        for (int p = 0; p <= 5; p++)
        begin
            if (p > 0)
            begin
                item_valid <= 1'b0;
                wait_idle();
                program_limits(set_books[p-1], set_frames[p-1], set_text[p-1]);
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                steady = ($urandom_range(0, 5) == 0);
                build_buffer();
                for (int i = 0; i < pkt_bytes.size(); i++)
                    send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, vcsp_pkg::ERR_NONE);
                buffers_sent++;
            end
        end
        steady = 1'b0;
        item_valid <= 1'b0;
        wait_idle();
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("covered %0d bytes in %0d buffers over 6 limit settings", bytes_sent,
                 buffers_sent + 5);
        $display("checked %0d text, %0d code, %0d accepted, %0d rejected beats",
                 text_seen, codes_seen, accepts_seen, rejects_seen);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
